// ===== rtl/searchable_lifo_stack_defines.svh =====
// Assertion macros for the searchable LIFO stack.
// Used by the RTL files that carry concurrent checks; compiled out under SYNTH.
`ifndef SEARCHABLE_LIFO_STACK_DEFINES_SVH
`define SEARCHABLE_LIFO_STACK_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define SLS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("searchable_lifo_stack: check failed");

// next-cycle implication
`define SLS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("searchable_lifo_stack: check failed");

`else

`define SLS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SLS_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/sls_pkg.sv =====
// Shared types, codes and constants of the searchable LIFO stack.
// No dependencies; imported by every module of the block but sls_ram.
package sls_pkg;

   localparam int DEPTH_DEF      = 64;
   localparam int DATA_BYTES_DEF = 4;

   localparam int DATA_W     = 32;
   localparam int CMD_W      = 3;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 7;
   localparam int BYTES_W    = 9;
   localparam int LIMIT_W    = 7;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [LIMIT_W-1:0]    LIMIT_RESET     = 7'd64;
   localparam logic [CSR_ADDR_W-1:0] ADDR_FULL_LIMIT = 2'd0;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH         = 3'd0,
      CMD_POP          = 3'd1,
      CMD_PEEK         = 3'd2,
      CMD_CLEAR        = 3'd3,
      CMD_REMOVE_FIRST = 3'd4,
      CMD_REMOVE_ALL   = 3'd5,
      CMD_CONTAINS     = 3'd6,
      CMD_REVERSE      = 3'd7
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK   = 2'd0,
      STS_MISS = 2'd1,
      STS_FULL = 2'd2
   } status_type;

   typedef struct packed {
      status_type         status;
      logic [DATA_W-1:0]  data_out;
      logic               found;
      logic [COUNT_W-1:0] drop_count;
      logic [COUNT_W-1:0] entry_count;
      logic [BYTES_W-1:0] total_bytes;
      logic               is_empty;
      logic               is_full;
   } result_type;

   function automatic int key_width(input int bytes);
      return (bytes >= 4) ? DATA_W : 8 * bytes;
   endfunction

endpackage

// ===== rtl/searchable_lifo_stack.sv =====
// searchable_lifo_stack: bounded LIFO of data words with search, remove and reverse.
// Depends on sls_pkg, sls_csr, sls_ctrl and sls_ram.
// Commands enter on req_* (valid/ready); each gives one result transfer on rsp_*.
// The entries sit in one RAM with a registered read port; each command runs as a
// sequence of RAM reads and writes, one command at a time. Pop and peek read the top
// entry; contains and remove first scan down from the top to the first match, and
// remove first then moves each entry above the match down; remove all passes over
// every entry and packs the survivors down; reverse swaps entries in pairs from the
// two ends inward. Push, clear and any command on an empty stack need no RAM read.
// req_ready returns in the cycle rsp_valid rises.
// A finished result waits in the output register; while it waits the next command
// is accepted and runs, and stalls only at its own end until rsp_ready frees it.
// full_limit sits on the csr_* port, write it while no command is in flight.
// Reset empties the stack and sets full_limit to 64; no clearing pass is needed.
module searchable_lifo_stack #(
   parameter int DEPTH      = sls_pkg::DEPTH_DEF,
   parameter int DATA_BYTES = sls_pkg::DATA_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [sls_pkg::CMD_W-1:0]        req_cmd,
   input  logic [sls_pkg::DATA_W-1:0]       req_data_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [sls_pkg::STATUS_W-1:0]     rsp_status,
   output logic [sls_pkg::DATA_W-1:0]       rsp_data_out,
   output logic                             rsp_found,
   output logic [sls_pkg::COUNT_W-1:0]      rsp_drop_count,
   output logic [sls_pkg::COUNT_W-1:0]      rsp_entry_count,
   output logic [sls_pkg::BYTES_W-1:0]      rsp_total_bytes,
   output logic                             rsp_is_empty,
   output logic                             rsp_is_full,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sls_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [sls_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [sls_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   import sls_pkg::*;

   localparam int KEY_W  = key_width(DATA_BYTES);
   localparam int ADDR_W = $clog2(DEPTH);

   logic [LIMIT_W-1:0] full_limit;
   logic               res_valid;
   logic               res_ready;
   result_type         res;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [KEY_W-1:0]   mem_wdata;
   logic               mem_re;
   logic [ADDR_W-1:0]  mem_raddr;
   logic [KEY_W-1:0]   mem_rdata;

   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff,       rsp_in;

   sls_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .full_limit  (full_limit)
   );

   sls_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_BYTES (DATA_BYTES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_cmd    (cmd_type'(req_cmd)),
      .req_data   (req_data_in),
      .full_limit (full_limit),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_re     (mem_re),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

   sls_ram #(
      .WIDTH (KEY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_data_out    = rsp_ff.data_out;
   assign rsp_found       = rsp_ff.found;
   assign rsp_drop_count  = rsp_ff.drop_count;
   assign rsp_entry_count = rsp_ff.entry_count;
   assign rsp_total_bytes = rsp_ff.total_bytes;
   assign rsp_is_empty    = rsp_ff.is_empty;
   assign rsp_is_full     = rsp_ff.is_full;

endmodule

// ===== rtl/sls_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sls_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/sls_csr.sv =====
// Configuration register file of the searchable LIFO stack (full_limit).
// Depends on sls_pkg.
module sls_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sls_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [sls_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [sls_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output logic [sls_pkg::LIMIT_W-1:0]      full_limit
);

   import sls_pkg::*;

   logic [LIMIT_W-1:0] full_limit_ff;
   logic [LIMIT_W-1:0] full_limit_in;
   logic               wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == ADDR_FULL_LIMIT);

   always_comb begin
      full_limit_in = full_limit_ff;
      if (wr_hit) begin
         full_limit_in = csr_pwdata[LIMIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_limit_ff <= LIMIT_RESET;
      end else begin
         full_limit_ff <= full_limit_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == ADDR_FULL_LIMIT) begin
         csr_prdata = CSR_DATA_W'(full_limit_ff);
      end
   end

   assign full_limit = full_limit_ff;

endmodule

// ===== rtl/sls_ctrl.sv =====
// Command sequencer of the searchable LIFO stack: fill count, scans and
// read-modify-write walks over the entry RAM. Depends on sls_pkg and the defines header.
`include "searchable_lifo_stack_defines.svh"

module sls_ctrl #(
   parameter int DEPTH      = sls_pkg::DEPTH_DEF,
   parameter int DATA_BYTES = sls_pkg::DATA_BYTES_DEF,
   localparam int KEY_W  = sls_pkg::key_width(DATA_BYTES),
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  sls_pkg::cmd_type              req_cmd,
   input  logic [sls_pkg::DATA_W-1:0]    req_data,
   input  logic [sls_pkg::LIMIT_W-1:0]   full_limit,
   output logic                          res_valid,
   input  logic                          res_ready,
   output sls_pkg::result_type           res,
   output logic                          mem_we,
   output logic [ADDR_W-1:0]             mem_waddr,
   output logic [KEY_W-1:0]              mem_wdata,
   output logic                          mem_re,
   output logic [ADDR_W-1:0]             mem_raddr,
   input  logic [KEY_W-1:0]              mem_rdata
);

   import sls_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);
   localparam logic [CNT_W-1:0] TWO      = CNT_W'(2);

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_RDWAIT  = 9'b000000010,
      ST_SCAN    = 9'b000000100,
      ST_SHIFT   = 9'b000001000,
      ST_COMPACT = 9'b000010000,
      ST_REV_A   = 9'b000100000,
      ST_REV_B   = 9'b001000000,
      ST_REV_C   = 9'b010000000,
      ST_FIN     = 9'b100000000
   } state_type;

   state_type        state_ff,   state_in;
   logic [CNT_W-1:0] fill_ff,    fill_in;
   cmd_type          cmd_ff,     cmd_in;
   logic [KEY_W-1:0] key_ff,     key_in;
   status_type       status_ff,  status_in;
   logic [KEY_W-1:0] dout_ff,    dout_in;
   logic             found_ff,   found_in;
   logic [CNT_W-1:0] removed_ff, removed_in;
   logic [CNT_W-1:0] ia_ff,      ia_in;
   logic [CNT_W-1:0] ib_ff,      ib_in;
   logic [KEY_W-1:0] tmp_ff,     tmp_in;

   logic [KEY_W-1:0] req_key;
   logic             hit;
   logic             req_acc;
   logic [CNT_W-1:0] fill_m1;
   logic [CNT_W-1:0] ia_p1, ia_p2, ia_m1;
   logic [CNT_W-1:0] ib_p1, ib_p2, ib_m1;
   logic [31:0]      fill_w, removed_w, bytes_w;

   assign req_key   = req_data[KEY_W-1:0];
   assign hit       = (mem_rdata == key_ff);
   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign res_valid = (state_ff == ST_FIN);

   assign fill_m1 = fill_ff - ONE;
   assign ia_p1   = ia_ff + ONE;
   assign ia_p2   = ia_ff + TWO;
   assign ia_m1   = ia_ff - ONE;
   assign ib_p1   = ib_ff + ONE;
   assign ib_p2   = ib_ff + TWO;
   assign ib_m1   = ib_ff - ONE;

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      cmd_in     = cmd_ff;
      key_in     = key_ff;
      status_in  = status_ff;
      dout_in    = dout_ff;
      found_in   = found_ff;
      removed_in = removed_ff;
      ia_in      = ia_ff;
      ib_in      = ib_ff;
      tmp_in     = tmp_ff;
      mem_we     = 1'b0;
      mem_waddr  = ia_ff[ADDR_W-1:0];
      mem_wdata  = mem_rdata;
      mem_re     = 1'b0;
      mem_raddr  = ia_ff[ADDR_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               cmd_in     = req_cmd;
               key_in     = req_key;
               status_in  = STS_OK;
               dout_in    = '0;
               found_in   = 1'b0;
               removed_in = '0;
               state_in   = ST_FIN;
               case (req_cmd)
                  CMD_PUSH: begin
                     if (fill_ff == FILL_MAX) begin
                        status_in = STS_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = fill_ff[ADDR_W-1:0];
                        mem_wdata = req_key;
                        fill_in   = fill_ff + ONE;
                     end
                  end
                  CMD_POP, CMD_PEEK: begin
                     if (fill_ff == '0) begin
                        status_in = STS_MISS;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = fill_m1[ADDR_W-1:0];
                        state_in  = ST_RDWAIT;
                     end
                  end
                  CMD_CLEAR: begin
                     fill_in = '0;
                  end
                  CMD_REMOVE_FIRST, CMD_CONTAINS: begin
                     if (fill_ff == '0) begin
                        status_in = STS_MISS;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = fill_m1[ADDR_W-1:0];
                        ia_in     = fill_m1;
                        state_in  = ST_SCAN;
                     end
                  end
                  CMD_REMOVE_ALL: begin
                     if (fill_ff == '0) begin
                        status_in = STS_MISS;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = '0;
                        ia_in     = '0;
                        ib_in     = '0;
                        state_in  = ST_COMPACT;
                     end
                  end
                  CMD_REVERSE: begin
                     if (fill_ff > ONE) begin
                        mem_re    = 1'b1;
                        mem_raddr = '0;
                        ia_in     = '0;
                        ib_in     = fill_m1;
                        state_in  = ST_REV_A;
                     end
                  end
                  default: begin
                     state_in = ST_FIN;
                  end
               endcase
            end
         end
         ST_RDWAIT: begin
            dout_in  = mem_rdata;
            state_in = ST_FIN;
            if (cmd_ff == CMD_POP) begin
               fill_in = fill_m1;
            end
         end
         ST_SCAN: begin
            // walk down from the top, one compare per cycle
            if (hit) begin
               found_in = 1'b1;
               state_in = ST_FIN;
               if (cmd_ff == CMD_REMOVE_FIRST) begin
                  removed_in = ONE;
                  if (ia_ff == fill_m1) begin
                     fill_in = fill_m1;
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = ia_p1[ADDR_W-1:0];
                     ib_in     = ia_ff;
                     state_in  = ST_SHIFT;
                  end
               end
            end else if (ia_ff == '0) begin
               status_in = STS_MISS;
               state_in  = ST_FIN;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = ia_m1[ADDR_W-1:0];
               ia_in     = ia_m1;
            end
         end
         ST_SHIFT: begin
            // move entry ib+1 down to ib, read ahead the next one
            mem_we    = 1'b1;
            mem_waddr = ib_ff[ADDR_W-1:0];
            mem_wdata = mem_rdata;
            ib_in     = ib_p1;
            if (ib_p2 == fill_ff) begin
               fill_in  = fill_m1;
               state_in = ST_FIN;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = ib_p2[ADDR_W-1:0];
            end
         end
         ST_COMPACT: begin
            // drop matches, pack survivors down in order
            if (hit) begin
               removed_in = removed_ff + ONE;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = ib_ff[ADDR_W-1:0];
               mem_wdata = mem_rdata;
               ib_in     = ib_p1;
            end
            if (ia_p1 == fill_ff) begin
               fill_in  = ib_in;
               state_in = ST_FIN;
               if (removed_in == '0) begin
                  status_in = STS_MISS;
               end else begin
                  found_in = 1'b1;
               end
            end else begin
               mem_re    = 1'b1;
               mem_raddr = ia_p1[ADDR_W-1:0];
               ia_in     = ia_p1;
            end
         end
         ST_REV_A: begin
            tmp_in    = mem_rdata;
            mem_re    = 1'b1;
            mem_raddr = ib_ff[ADDR_W-1:0];
            state_in  = ST_REV_B;
         end
         ST_REV_B: begin
            mem_we    = 1'b1;
            mem_waddr = ia_ff[ADDR_W-1:0];
            mem_wdata = mem_rdata;
            state_in  = ST_REV_C;
         end
         ST_REV_C: begin
            mem_we    = 1'b1;
            mem_waddr = ib_ff[ADDR_W-1:0];
            mem_wdata = tmp_ff;
            ia_in     = ia_p1;
            ib_in     = ib_m1;
            if (ia_p2 < ib_ff) begin
               mem_re    = 1'b1;
               mem_raddr = ia_p1[ADDR_W-1:0];
               state_in  = ST_REV_A;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      key_ff     <= key_in;
      status_ff  <= status_in;
      dout_ff    <= dout_in;
      found_ff   <= found_in;
      removed_ff <= removed_in;
      ia_ff      <= ia_in;
      ib_ff      <= ib_in;
      tmp_ff     <= tmp_in;
   end

   assign fill_w    = 32'(fill_ff);
   assign removed_w = 32'(removed_ff);
   assign bytes_w   = 32'(fill_w * 32'(DATA_BYTES));

   always_comb begin
      res.status      = status_ff;
      res.data_out    = DATA_W'(dout_ff);
      res.found       = found_ff;
      res.drop_count  = removed_w[COUNT_W-1:0];
      res.entry_count = fill_w[COUNT_W-1:0];
      res.total_bytes = bytes_w[BYTES_W-1:0];
      res.is_empty    = (fill_ff == '0);
      res.is_full     = (fill_w >= 32'(full_limit));
   end

   `SLS_ASSERT_IMP(a_fill_bound, clock, reset, 1'b1, fill_ff <= FILL_MAX)
   `SLS_ASSERT_IMP(a_no_rw_clash, clock, reset, mem_we && mem_re, mem_waddr != mem_raddr)
   `SLS_ASSERT_IMP(a_fin_quiet, clock, reset, state_ff == ST_FIN, !mem_we && !mem_re)
   `SLS_ASSERT_NXT(a_push_grows, clock, reset,
      req_acc && (req_cmd == CMD_PUSH) && (fill_ff != FILL_MAX),
      fill_ff == $past(fill_ff) + ONE)

endmodule

// ===== verif/tb_searchable_lifo_stack.sv =====
// Self-checking bench for searchable_lifo_stack: commands on req_*, results on rsp_*.
// A shadow LIFO in the scoreboard class predicts each result transfer; depends on sls_pkg.
// Directed edge cases first, then random phases with full_limit rewritten between them.
module tb_searchable_lifo_stack;
   timeunit 1ns;
   timeprecision 1ps;
   import sls_pkg::*;

   localparam int QUIET_LIMIT = 3000;
   localparam int LONG_HOLD   = 300;

   class lifo_tracker;
      logic [DATA_W-1:0]  words [DEPTH_DEF];
      int                 depth_used = 0;
      logic [LIMIT_W-1:0] full_limit = LIMIT_RESET;
      result_type         pending_results [$];
      int unsigned        errors = 0;

      function void set_full_limit(input logic [LIMIT_W-1:0] value);
         full_limit = value;
      endfunction

      function int unsigned pending();
         return pending_results.size();
      endfunction

      function int top_match(input logic [DATA_W-1:0] key);
         int i;
         for (i = depth_used - 1; i >= 0; i--) begin
            if (words[i] == key) return i;
         end
         return -1;
      endfunction

      function void note_command(input cmd_type cmd, input logic [DATA_W-1:0] key);
         result_type       r;
         int               i, pos, keep, lo, hi;
         logic [DATA_W-1:0] t;
         r = '0;
         r.status = STS_OK;
         case (cmd)
            CMD_PUSH: begin
               if (depth_used >= DEPTH_DEF) r.status = STS_FULL;
               else begin
                  words[depth_used] = key;
                  depth_used++;
               end
            end
            CMD_POP, CMD_PEEK: begin
               if (depth_used == 0) r.status = STS_MISS;
               else begin
                  r.data_out = words[depth_used - 1];
                  if (cmd == CMD_POP) depth_used--;
               end
            end
            CMD_CLEAR: depth_used = 0;
            CMD_REMOVE_FIRST: begin
               pos = top_match(key);
               if (pos < 0) r.status = STS_MISS;
               else begin
                  for (i = pos; i + 1 < depth_used; i++) words[i] = words[i + 1];
                  depth_used--;
                  r.found = 1'b1;
                  r.drop_count = COUNT_W'(1);
               end
            end
            CMD_REMOVE_ALL: begin
               keep = 0;
               for (i = 0; i < depth_used; i++) begin
                  if (words[i] == key) r.drop_count++;
                  else begin
                     words[keep] = words[i];
                     keep++;
                  end
               end
               depth_used = keep;
               if (r.drop_count == 0) r.status = STS_MISS;
               else r.found = 1'b1;
            end
            CMD_CONTAINS: begin
               if (top_match(key) >= 0) r.found = 1'b1;
               else r.status = STS_MISS;
            end
            default: begin
               lo = 0;
               hi = depth_used - 1;
               while (lo < hi) begin
                  t = words[lo];
                  words[lo] = words[hi];
                  words[hi] = t;
                  lo++;
                  hi--;
               end
            end
         endcase
         r.entry_count = COUNT_W'(depth_used);
         r.total_bytes = BYTES_W'(depth_used * DATA_BYTES_DEF);
         r.is_empty    = (depth_used == 0);
         r.is_full     = (depth_used >= int'(full_limit));
         pending_results.push_back(r);
      endfunction

      function void compare_field(input string name, input logic [DATA_W-1:0] want,
                                  input logic [DATA_W-1:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(input result_type got);
         result_type want;
         if (pending_results.size() == 0) begin
            $error("result transfer with no command outstanding");
            errors++;
            return;
         end
         want = pending_results.pop_front();
         compare_field("status", DATA_W'(want.status), DATA_W'(got.status));
         compare_field("data_out", want.data_out, got.data_out);
         compare_field("found", DATA_W'(want.found), DATA_W'(got.found));
         compare_field("drop_count", DATA_W'(want.drop_count), DATA_W'(got.drop_count));
         compare_field("entry_count", DATA_W'(want.entry_count),
                       DATA_W'(got.entry_count));
         compare_field("total_bytes", DATA_W'(want.total_bytes),
                       DATA_W'(got.total_bytes));
         compare_field("is_empty", DATA_W'(want.is_empty), DATA_W'(got.is_empty));
         compare_field("is_full", DATA_W'(want.is_full), DATA_W'(got.is_full));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [CMD_W-1:0]      req_cmd = '0;
   logic [DATA_W-1:0]     req_data_in = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [DATA_W-1:0]     rsp_data_out;
   logic                  rsp_found;
   logic [COUNT_W-1:0]    rsp_drop_count;
   logic [COUNT_W-1:0]    rsp_entry_count;
   logic [BYTES_W-1:0]    rsp_total_bytes;
   logic                  rsp_is_empty;
   logic                  rsp_is_full;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   lifo_tracker       sb;
   bit                idle_on = 1'b1;
   bit                long_stall_req = 1'b0;
   logic [DATA_W-1:0] key_pool [8];

   cmd_type dir_cmd [23] = '{
      CMD_POP, CMD_PEEK, CMD_REMOVE_FIRST, CMD_REMOVE_ALL, CMD_CONTAINS, CMD_REVERSE,
      CMD_PUSH, CMD_PUSH, CMD_PUSH, CMD_PEEK, CMD_REVERSE, CMD_POP, CMD_CONTAINS,
      CMD_CONTAINS, CMD_PUSH, CMD_REMOVE_FIRST, CMD_PUSH, CMD_REMOVE_ALL, CMD_REVERSE,
      CMD_CLEAR, CMD_PUSH, CMD_POP, CMD_POP};
   logic [DATA_W-1:0] dir_data [23] = '{
      32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
      32'h0, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF,
      32'h1234_5678, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,
      32'h0, 32'h5A5A_5A5A, 32'h0, 32'h0};

   searchable_lifo_stack u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_data_in     (req_data_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_data_out    (rsp_data_out),
      .rsp_found       (rsp_found),
      .rsp_drop_count  (rsp_drop_count),
      .rsp_entry_count (rsp_entry_count),
      .rsp_total_bytes (rsp_total_bytes),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic send_cmd(input cmd_type c, input logic [DATA_W-1:0] d);
      if (idle_on && $urandom_range(3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(17, 1)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_cmd     <= c;
      req_data_in <= d;
      do @(posedge clock); while (!req_ready);
      sb.note_command(c, d);
   endtask

   task automatic run_random(input int count, input int push_pct, input bit clear_ok);
      cmd_type           c;
      logic [DATA_W-1:0] d;
      repeat (count) begin
         if ($urandom_range(99) < push_pct) c = CMD_PUSH;
         else c = cmd_type'($urandom_range(7, 1));
         if (!clear_ok && c == CMD_CLEAR) c = CMD_PUSH;
         if ($urandom_range(9) < 8) d = key_pool[$urandom_range(7)];
         else d = $urandom();
         send_cmd(c, d);
      end
   endtask

   task automatic settle(input int extra);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_full_limit(input logic [LIMIT_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_FULL_LIMIT;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_full_limit(value);
   endtask

   // result side: check each transfer, then pick ready for the next cycle
   initial begin : result_sink
      result_type got;
      int         stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.status      = status_type'(rsp_status);
            got.data_out    = rsp_data_out;
            got.found       = rsp_found;
            got.drop_count  = rsp_drop_count;
            got.entry_count = rsp_entry_count;
            got.total_bytes = rsp_total_bytes;
            got.is_empty    = rsp_is_empty;
            got.is_full     = rsp_is_full;
            sb.check_result(got);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (long_stall_req) begin
            // hold off long enough for the block to back up its input
            long_stall_req = 1'b0;
            stall_left = LONG_HOLD;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(9) == 0) begin
            stall_left = $urandom_range(16, 0);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_psel && csr_penable)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("FAIL");
      $finish;
   end

   initial begin : stimulus
      int i;
      sb = new();
      for (i = 0; i < 8; i++) key_pool[i] = $urandom();
      key_pool[0] = '0;
      key_pool[1] = '1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < 23; i++) send_cmd(dir_cmd[i], dir_data[i]);

      settle(4);
      write_full_limit(7'd0);
      run_random(60, 60, 1'b1);

      // fill toward capacity with mostly pushes and no clears; the result side stalls first
      settle(4);
      write_full_limit(7'd64);
      long_stall_req = 1'b1;
      run_random(90, 90, 1'b0);

      settle(4);
      write_full_limit(7'd127);
      run_random(100, 40, 1'b1);

      settle(4);
      write_full_limit(LIMIT_W'($urandom_range(63, 1)));
      run_random(100, 55, 1'b1);

      settle(4);
      write_full_limit(7'd32);
      idle_on = 1'b0;
      run_random(100, 50, 1'b1);

      settle(120);
      if (sb.pending() != 0) begin
         $error("%0d expected results never arrived", sb.pending());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
